// ===== src/asmc_pkg.sv =====
// Shared widths, request and register codes and chain types for the AABB step-move block.
// Used by asmc_cell, asmc_ctrl and aabb_step_move_collide; no dependencies.
package asmc_pkg;

  localparam int MaxSolidsDef = 16;

  localparam int CountW = 5;   // solid_count register
  localparam int DimW   = 12;  // rectangle width and height
  localparam int CoordW = 16;  // signed coordinates
  localparam int ExtW   = 17;  // coordinate plus extent, no wrap
  localparam int AmtW   = 8;   // signed move amount and step count
  localparam int StepW  = 8;   // unsigned step index, 1 to 128
  localparam int SlotW  = 4;   // solid table slot

  // Request opcodes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_MOVE_X  = 2'd1,
    OP_MOVE_Y  = 2'd2,
    OP_SET_POS = 2'd3
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_SOLID_COUNT  = 2'd0;
  localparam logic [1:0] CFG_ACTOR_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_ACTOR_HEIGHT = 2'd2;

  // One candidate position travelling down the cell chain
  typedef struct packed {
    logic              valid;
    logic [StepW-1:0]  idx;
    logic              hit;
    logic [CoordW-1:0] x;
    logic [ExtW-1:0]   xr;
    logic [CoordW-1:0] y;
    logic [ExtW-1:0]   yb;
  } probe_t;

  // Broadcast write of one solid entry
  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
  } solid_wr_t;

endpackage

// ===== src/asmc_cell.sv =====
// One chain cell: holds one solid rectangle and tests passing candidates.
// Depends on asmc_pkg (probe_t, solid_wr_t, widths).
module asmc_cell #(
  parameter int Idx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [asmc_pkg::CountW-1:0]   solid_count_i,
  input  asmc_pkg::solid_wr_t           wr_i,
  input  logic                          kill_i,
  input  asmc_pkg::probe_t              probe_i,
  output asmc_pkg::probe_t              probe_o
);

  logic [asmc_pkg::CoordW-1:0] sl_q, st_q;
  logic [asmc_pkg::ExtW-1:0]   sr_q, sb_q;
  logic                        wr_hit;
  logic                        active;
  logic                        overlap;
  logic                        valid_q;
  asmc_pkg::probe_t            probe_d, probe_q;

  assign wr_hit = wr_i.en && (32'(wr_i.slot) == Idx);
  assign active = 32'(solid_count_i) > Idx;

  // Store edges; right and bottom are kept pre-added
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      sl_q <= wr_i.left;
      st_q <= wr_i.top;
      sr_q <= {wr_i.left[asmc_pkg::CoordW-1], wr_i.left} +
              {{(asmc_pkg::ExtW-asmc_pkg::DimW){1'b0}}, wr_i.w};
      sb_q <= {wr_i.top[asmc_pkg::CoordW-1], wr_i.top} +
              {{(asmc_pkg::ExtW-asmc_pkg::DimW){1'b0}}, wr_i.h};
    end
  end

  // Strict overlap of the candidate against this solid
  assign overlap =
    ($signed({sl_q[asmc_pkg::CoordW-1], sl_q}) < $signed(probe_i.xr)) &&
    ($signed(sr_q) > $signed({probe_i.x[asmc_pkg::CoordW-1], probe_i.x})) &&
    ($signed({st_q[asmc_pkg::CoordW-1], st_q}) < $signed(probe_i.yb)) &&
    ($signed(sb_q) > $signed({probe_i.y[asmc_pkg::CoordW-1], probe_i.y}));

  always_comb begin
    probe_d     = probe_i;
    probe_d.hit = probe_i.hit || (active && overlap);
  end

  // Advance the candidate one cell; kill flushes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= probe_i.valid && !kill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    probe_q <= probe_d;
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = valid_q;
  end

endmodule

// ===== src/asmc_ctrl.sv =====
// Request decode, actor position and move sequencing for the cell chain.
// Depends on asmc_pkg (probe_t, solid_wr_t, opcodes, widths).
module asmc_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [asmc_pkg::SlotW-1:0]         slot_i,
  input  logic signed [asmc_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [asmc_pkg::CoordW-1:0] coord_y_i,
  input  logic [asmc_pkg::DimW-1:0]          rect_width_i,
  input  logic [asmc_pkg::DimW-1:0]          rect_height_i,
  input  logic signed [asmc_pkg::AmtW-1:0]   move_amount_i,
  input  logic [asmc_pkg::DimW-1:0]          actor_width_i,
  input  logic [asmc_pkg::DimW-1:0]          actor_height_i,
  output asmc_pkg::solid_wr_t                solid_wr_o,
  output asmc_pkg::probe_t                   head_o,
  input  asmc_pkg::probe_t                   tail_i,
  output logic                               kill_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [asmc_pkg::CoordW-1:0] pos_x_o,
  output logic signed [asmc_pkg::CoordW-1:0] pos_y_o,
  output logic signed [asmc_pkg::AmtW-1:0]   steps_taken_o,
  output logic                               blocked_o
);

  localparam int CW = asmc_pkg::CoordW;
  localparam int EW = asmc_pkg::ExtW;
  localparam int SW = asmc_pkg::StepW;

  typedef enum logic {StIdle, StRun} state_e;

  state_e        state_q;
  logic [CW-1:0] pos_x_q, pos_y_q;
  logic          axis_q;   // 1: move along y
  logic          neg_q;
  logic [SW-1:0] cnt_q;    // candidates this move
  logic [SW-1:0] iss_q;    // candidates issued so far
  logic          out_valid_q;
  logic [CW-1:0] out_x_q, out_y_q;
  logic [asmc_pkg::AmtW-1:0] out_steps_q;
  logic          out_blk_q;

  logic          accept;
  logic [8:0]    amt9, mag9;
  logic [EW-1:0] acc_ax, room;
  logic [SW-1:0] count;
  logic [EW-1:0] run_ax, cand;
  logic [SW-1:0] nxt_idx;
  logic [CW-1:0] hx, hy;
  logic          issue;
  logic          resolve;
  logic [SW-1:0] res_mag;
  logic [asmc_pkg::AmtW-1:0] steps;
  logic [EW-1:0] new_ax;

  assign in_ready_o = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Solid writes go straight to every cell
  always_comb begin
    solid_wr_o.en   = accept && (op_i == asmc_pkg::OP_WRITE);
    solid_wr_o.slot = slot_i;
    solid_wr_o.left = coord_x_i;
    solid_wr_o.top  = coord_y_i;
    solid_wr_o.w    = rect_width_i;
    solid_wr_o.h    = rect_height_i;
  end

  // Number of candidates: magnitude, cut at the coordinate edge
  assign amt9   = {move_amount_i[asmc_pkg::AmtW-1], move_amount_i};
  assign mag9   = move_amount_i[asmc_pkg::AmtW-1] ? 9'(9'd0 - amt9) : amt9;
  assign acc_ax = (op_i == asmc_pkg::OP_MOVE_Y) ? {pos_y_q[CW-1], pos_y_q}
                                                : {pos_x_q[CW-1], pos_x_q};
  assign room   = move_amount_i[asmc_pkg::AmtW-1] ? (acc_ax + 17'd32768)
                                                  : (17'd32767 - acc_ax);
  assign count  = ({8'b0, mag9} < room) ? mag9[SW-1:0] : room[SW-1:0];

  // Next candidate along the move axis
  assign run_ax  = axis_q ? {pos_y_q[CW-1], pos_y_q} : {pos_x_q[CW-1], pos_x_q};
  assign nxt_idx = iss_q + 8'd1;
  assign cand    = neg_q ? (run_ax - {{(EW-SW){1'b0}}, nxt_idx})
                         : (run_ax + {{(EW-SW){1'b0}}, nxt_idx});
  assign hx      = axis_q ? pos_x_q : cand[CW-1:0];
  assign hy      = axis_q ? cand[CW-1:0] : pos_y_q;

  // The first candidate out of the chain that hits, or the last one, ends the move
  assign resolve = (state_q == StRun) && tail_i.valid &&
                   (tail_i.hit || (tail_i.idx == cnt_q));
  assign issue   = (state_q == StRun) && (iss_q != cnt_q) && !resolve;
  assign kill_o  = resolve;

  always_comb begin
    head_o.valid = issue;
    head_o.idx   = nxt_idx;
    head_o.hit   = 1'b0;
    head_o.x     = hx;
    head_o.y     = hy;
    head_o.xr    = {hx[CW-1], hx} + {{(EW-asmc_pkg::DimW){1'b0}}, actor_width_i};
    head_o.yb    = {hy[CW-1], hy} + {{(EW-asmc_pkg::DimW){1'b0}}, actor_height_i};
  end

  assign res_mag = tail_i.hit ? (tail_i.idx - 8'd1) : cnt_q;
  assign steps   = neg_q ? (8'd0 - res_mag) : res_mag;
  assign new_ax  = run_ax + {{(EW-asmc_pkg::AmtW){steps[asmc_pkg::AmtW-1]}}, steps};

  // Hold state, position and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      axis_q      <= 1'b0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_steps_q <= '0;
      out_blk_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            unique case (op_i) inside
              asmc_pkg::OP_WRITE: begin
                out_valid_q <= 1'b1;
                out_x_q     <= pos_x_q;
                out_y_q     <= pos_y_q;
                out_steps_q <= '0;
                out_blk_q   <= 1'b0;
              end
              asmc_pkg::OP_SET_POS: begin
                pos_x_q     <= coord_x_i;
                pos_y_q     <= coord_y_i;
                out_valid_q <= 1'b1;
                out_x_q     <= coord_x_i;
                out_y_q     <= coord_y_i;
                out_steps_q <= '0;
                out_blk_q   <= 1'b0;
              end
              asmc_pkg::OP_MOVE_X, asmc_pkg::OP_MOVE_Y: begin
                axis_q <= (op_i == asmc_pkg::OP_MOVE_Y);
                neg_q  <= move_amount_i[asmc_pkg::AmtW-1];
                cnt_q  <= count;
                iss_q  <= '0;
                if (count == '0) begin
                  out_valid_q <= 1'b1;
                  out_x_q     <= pos_x_q;
                  out_y_q     <= pos_y_q;
                  out_steps_q <= '0;
                  out_blk_q   <= 1'b0;
                end else begin
                  state_q <= StRun;
                end
              end
            endcase
          end
        end
        StRun: begin
          if (issue) begin
            iss_q <= nxt_idx;
          end
          if (resolve) begin
            if (axis_q) begin
              pos_y_q <= new_ax[CW-1:0];
              out_y_q <= new_ax[CW-1:0];
              out_x_q <= pos_x_q;
            end else begin
              pos_x_q <= new_ax[CW-1:0];
              out_x_q <= new_ax[CW-1:0];
              out_y_q <= pos_y_q;
            end
            out_valid_q <= 1'b1;
            out_steps_q <= steps;
            out_blk_q   <= tail_i.hit;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = out_x_q;
  assign pos_y_o       = out_y_q;
  assign steps_taken_o = out_steps_q;
  assign blocked_o     = out_blk_q;

  // Never issue more candidates than the move allows
  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (iss_q <= cnt_q))
    else $error("issued count exceeds candidate count");

  // A candidate leaving the chain was issued during this move
  a_tail_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StRun) && tail_i.valid) |-> ((tail_i.idx != '0) && (tail_i.idx <= iss_q)))
    else $error("chain returned a candidate that was not issued");

  // The chain is flushed whenever no move is running
  a_flushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !tail_i.valid)
    else $error("stale candidate in chain while idle");

  // A result appears only after an accepted request or a finished move
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(accept) || $past(state_q == StRun)))
    else $error("result raised without a source");

endmodule

// ===== src/aabb_step_move_collide.sv =====
// Top level of the AABB step-move block: configuration registers, the
// controller and the solid cell chain. Depends on asmc_pkg, asmc_ctrl, asmc_cell.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | request   | in_valid_i / in_ready_o | op, slot, coord_x/y, rect_width/height,
//           |           |                         | move_amount
//   out     | result    | out_valid_o/out_ready_i | pos_x/y, steps_taken, blocked
//   cfg     | write     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Solid writes, position sets and zero-length moves are answered from the idle state.
// A move of n candidate steps issues up to n candidates, one entering the cell chain
// per cycle, and each passes all MAX_SOLIDS cells; a hit flushes the chain and ends
// the move early. One request is in work at a time; a new one is taken once the result
// register is empty or being read. Reset zeroes the position and restores the
// configuration defaults; solid entries hold garbage until written.
module aabb_step_move_collide #(
  parameter int MAX_SOLIDS = asmc_pkg::MaxSolidsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [asmc_pkg::SlotW-1:0]         slot_i,
  input  logic signed [asmc_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [asmc_pkg::CoordW-1:0] coord_y_i,
  input  logic [asmc_pkg::DimW-1:0]          rect_width_i,
  input  logic [asmc_pkg::DimW-1:0]          rect_height_i,
  input  logic signed [asmc_pkg::AmtW-1:0]   move_amount_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [asmc_pkg::CoordW-1:0] pos_x_o,
  output logic signed [asmc_pkg::CoordW-1:0] pos_y_o,
  output logic signed [asmc_pkg::AmtW-1:0]   steps_taken_o,
  output logic                               blocked_o,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [asmc_pkg::DimW-1:0]          cfg_wdata_i
);

  logic [asmc_pkg::CountW-1:0] solid_count_q;
  logic [asmc_pkg::DimW-1:0]   actor_width_q, actor_height_q;
  asmc_pkg::solid_wr_t         solid_wr;
  asmc_pkg::probe_t            chain [MAX_SOLIDS+1];
  logic                        kill;

  // Hold configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      solid_count_q  <= '0;
      actor_width_q  <= 12'd8;
      actor_height_q <= 12'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asmc_pkg::CFG_SOLID_COUNT:  solid_count_q  <= cfg_wdata_i[asmc_pkg::CountW-1:0];
        asmc_pkg::CFG_ACTOR_WIDTH:  actor_width_q  <= cfg_wdata_i;
        asmc_pkg::CFG_ACTOR_HEIGHT: actor_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  asmc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .slot_i         (slot_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .move_amount_i  (move_amount_i),
    .actor_width_i  (actor_width_q),
    .actor_height_i (actor_height_q),
    .solid_wr_o     (solid_wr),
    .head_o         (chain[0]),
    .tail_i         (chain[MAX_SOLIDS]),
    .kill_o         (kill),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .steps_taken_o  (steps_taken_o),
    .blocked_o      (blocked_o)
  );

  // Row of solid cells; candidates advance one cell per cycle
  for (genvar i = 0; i < MAX_SOLIDS; i++) begin : g_cell
    asmc_cell #(.Idx(i)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .solid_count_i (solid_count_q),
      .wr_i          (solid_wr),
      .kill_i        (kill),
      .probe_i       (chain[i]),
      .probe_o       (chain[i+1])
    );
  end

endmodule
